FILE: hdl/cqf_pkg.sv
// ----------------------------------------------------------------------------
// cqf_pkg
// shared types and codes of the ring-buffer queue: opcodes, status codes,
// result word
// ----------------------------------------------------------------------------
package cqf_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 8;

    // opcodes carried in tuser of the input channel
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // status codes carried in tuser of the output channel
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_result;

endpackage

FILE: hdl/cqf_mem.sv
// ----------------------------------------------------------------------------
// cqf_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cqf_mem #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic signed [cqf_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic signed [cqf_pkg::DATA_W-1:0] o_rd_data
);
    import cqf_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/cqf_ctrl.sv
// ----------------------------------------------------------------------------
// cqf_ctrl
// sequencer of the queue: pointers, occupancy, dump walk, one shared
// pointer-advance unit
// ----------------------------------------------------------------------------
module cqf_ctrl #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [cqf_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [cqf_pkg::DATA_W-1:0] i_data,
    input  logic                              i_out_free,
    output logic                              o_res_load,
    output cqf_pkg::t_result                  o_res,
    output logic                              o_wr_en,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic signed [cqf_pkg::DATA_W-1:0] o_wr_data,
    output logic                              o_rd_en,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    input  logic signed [cqf_pkg::DATA_W-1:0] i_rd_data
);
    import cqf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DATA = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_walk, n_walk;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_is_del, n_is_del;

    logic             accept;
    logic [PTR_W-1:0] adv_in;
    logic [PTR_W-1:0] adv_out;

    // shared pointer-advance unit: tail while idle, walk pointer otherwise
    assign adv_in  = r_state[1] ? r_walk : r_tail;
    assign adv_out = (adv_in == PTR_LAST) ? '0 : adv_in + PTR_W'(1);

    assign o_ready   = (r_state == S_IDLE) && i_out_free;
    assign accept    = i_valid && o_ready;
    assign o_wr_addr = r_tail;
    assign o_wr_data = i_data;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_walk     = r_walk;
        n_occ      = r_occ;
        n_left     = r_left;
        n_is_del   = r_is_del;
        o_res_load = 1'b0;
        o_res      = '{status: ST_OK, value: '0, last: 1'b1};
        o_wr_en    = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_INSERT: begin
                            o_res_load = 1'b1;
                            if (r_occ == CNT_FULL) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_tail  = adv_out;
                                n_occ   = r_occ + CNT_ONE;
                            end
                        end
                        OP_DELETE, OP_DUMP: begin
                            if (r_occ == '0) begin
                                o_res_load   = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                o_rd_en  = 1'b1;
                                n_walk   = r_head;
                                n_is_del = (i_opcode == OP_DELETE);
                                n_left   = (i_opcode == OP_DELETE) ? CNT_ONE : r_occ;
                                n_state  = S_DATA;
                            end
                        end
                        default: begin
                            // unused opcode: no result, no change
                        end
                    endcase
                end
            end
            S_DATA: begin
                if (i_out_free) begin
                    o_res_load  = 1'b1;
                    o_res.value = i_rd_data;
                    o_res.last  = (r_left == CNT_ONE);
                    if (r_is_del) begin
                        n_head  = adv_out;
                        n_occ   = r_occ - CNT_ONE;
                        n_state = S_IDLE;
                    end else if (r_left == CNT_ONE) begin
                        n_state = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = adv_out;
                        n_walk    = adv_out;
                        n_left    = r_left - CNT_ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_left   <= '0;
            r_is_del <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_occ    <= n_occ;
            r_left   <= n_left;
            r_is_del <= n_is_del;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
    end

endmodule

FILE: hdl/circular_queue_fifo.sv
// ----------------------------------------------------------------------------
// circular_queue_fifo
// ring-buffer queue of signed 32-bit words with insert, delete and dump
// ----------------------------------------------------------------------------
// usage:
//   input channel s_axis: tuser carries the opcode (insert, delete, dump),
//   tdata the value to insert. opcode 3 is swallowed with no result.
//   output channel m_axis: tuser carries the status (ok, full, empty),
//   tdata the deleted or dumped value (zero otherwise), tlast marks the
//   final result of an item.
//   insert and every full or empty answer are loaded into the output register
//   as the item is taken; a delete, or the first entry of a dump, first passes
//   through the registered read port of the entry store.
//   an insert leaves the sequencer idle; a delete or a dump keeps it busy, and
//   no new item is taken, until its last result is loaded, one entry per read.
//   the input is ready only while the sequencer is idle and the output
//   register is free or being drained.
//   reset (synchronous, active low) empties the queue: head, tail and
//   occupancy go to zero; store contents are left as they are.
//   when the receiver stalls, the result stays in the output register and
//   the sequencer, including a dump in progress, waits.
// ----------------------------------------------------------------------------
module circular_queue_fifo #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [cqf_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] data_value
    input  logic [cqf_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] opcode
    // output channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [cqf_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_value
    output logic [cqf_pkg::ST_W-1:0]          m_axis_tuser,  // [1:0] status
    output logic                              m_axis_tlast
);
    import cqf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    // store port signals
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [PTR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    // result hand-off to the output register
    logic    res_load;
    t_result res;
    logic    out_free;

    logic    r_out_valid;
    t_result r_out;

    // output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    cqf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    cqf_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: valid is control, the result word is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

endmodule
